/* hw/rtl/vld_pkg.sv */
// Shared types and constants for the varint length-prefix deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package vld_pkg;

  // Length prefix layout
  localparam int unsigned LEN_W          = 29;
  localparam logic [2:0]  PREFIX_BYTES   = 3'd4;
  localparam logic [LEN_W-1:0] MAX_SIZE_RESET = 29'd8388608;

  // Error codes carried in a result word
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEN_ZERO = 2'd1,
    ERR_LEN_MAX  = 2'd2,
    ERR_LINK     = 2'd3
  } vld_err_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       link_error;
  } vld_in_t;

  // Result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
    logic [1:0] error_kind;
  } vld_out_t;

  // Status from the deframer core
  typedef struct packed {
    logic halted;
    logic in_content;
  } vld_status_t;

endpackage

`default_nettype wire

/* hw/rtl/varint_length_prefix_deframer.sv */
// Varint length-prefix deframer, top level. Uses vld_pkg, vld_core, vld_out_buf.
// Each content or error word is registered in the result buffer (main or skid entry) before out_.
// Throughput: one input word per cycle; the core decides each word combinationally
// and the two-entry result buffer holds input off only once both entries fill.
// Reset (rst_n low, synchronous): prefix phase, counters cleared, limit 8388608.
`default_nettype none

module varint_length_prefix_deframer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [vld_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire vld_pkg::vld_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output vld_pkg::vld_out_t              out_data
);
  import vld_pkg::*;

  logic        acc;
  logic        push;
  vld_out_t    push_data;
  vld_status_t status;
  logic        buf_full;

  assign acc      = in_valid && !buf_full;
  assign in_stall = buf_full;

  // Decode
  vld_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .word        (in_data),
    .res_valid   (push),
    .res         (push_data),
    .status      (status)
  );

  // Result buffering
  vld_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Halt is final until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.halted |=> status.halted)
    else $error("halt state left without reset");

  // Nothing is produced once halted
  a_no_result_halted: assert property (@(posedge clk) disable iff (!rst_n)
    status.halted |-> !push)
    else $error("result produced while halted");

  // Any error result halts the block
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_data.error_kind != ERR_NONE)) |=> status.halted)
    else $error("error result without halt");

  // Content words only come out of the content phase
  a_data_in_content: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_data.error_kind == ERR_NONE)) |-> status.in_content)
    else $error("content word outside content phase");

  // Skid entry only fills behind a held main entry
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid entry full with empty output");

endmodule

`default_nettype wire

/* hw/rtl/vld_core.sv */
// Deframer core: prefix decode, length check and content byte marking.
// Depends on vld_pkg. One word is processed per accepted cycle.
`default_nettype none

module vld_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [vld_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                      acc,
  input  wire vld_pkg::vld_in_t          word,
  output logic                           res_valid,
  output vld_pkg::vld_out_t              res,
  output vld_pkg::vld_status_t           status
);
  import vld_pkg::*;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       prefix_count_r, prefix_count_nxt;
  logic [LEN_W-1:0] length_accum_r, length_accum_nxt;
  logic [LEN_W-1:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [LEN_W-1:0] max_size_r;

  logic [2:0]       cnt_inc;
  logic [LEN_W-1:0] len_field;
  logic [LEN_W-1:0] accum_new;
  logic             prefix_done;
  logic             last_byte;

  // Place the prefix byte's bits by its position
  always_comb begin
    cnt_inc = prefix_count_r + 3'd1;
    case (cnt_inc)
      3'd1:    len_field = {22'd0, word.data_byte[6:0]};
      3'd2:    len_field = {15'd0, word.data_byte[6:0], 7'd0};
      3'd3:    len_field = {8'd0, word.data_byte[6:0], 14'd0};
      3'd4:    len_field = {word.data_byte, 21'd0};
      default: len_field = '0;
    endcase
    accum_new   = length_accum_r | len_field;
    prefix_done = !(word.data_byte[7] && (cnt_inc < PREFIX_BYTES));
    last_byte   = (bytes_remaining_r <= LEN_W'(1));
  end

  // Next state and result
  always_comb begin
    phase_nxt           = phase_r;
    prefix_count_nxt    = prefix_count_r;
    length_accum_nxt    = length_accum_r;
    bytes_remaining_nxt = bytes_remaining_r;
    res_valid           = 1'b0;
    res                 = '0;
    if (acc) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (word.link_error) begin
            res_valid      = 1'b1;
            res.error_kind = ERR_LINK;
            phase_nxt      = PH_HALT;
          end else begin
            prefix_count_nxt = cnt_inc;
            length_accum_nxt = accum_new;
            if (prefix_done) begin
              if (accum_new == '0) begin
                res_valid      = 1'b1;
                res.error_kind = ERR_LEN_ZERO;
                phase_nxt      = PH_HALT;
              end else if (accum_new > max_size_r) begin
                res_valid      = 1'b1;
                res.error_kind = ERR_LEN_MAX;
                phase_nxt      = PH_HALT;
              end else begin
                bytes_remaining_nxt = accum_new;
                phase_nxt           = PH_CONTENT;
              end
            end
          end
        end
        PH_CONTENT: begin
          res_valid = 1'b1;
          if (word.link_error) begin
            res.error_kind = ERR_LINK;
            phase_nxt      = PH_HALT;
          end else begin
            res.payload_byte     = word.data_byte;
            res.first_of_message = (bytes_remaining_r == length_accum_r);
            res.last_of_message  = last_byte;
            res.error_kind       = ERR_NONE;
            if (last_byte) begin
              bytes_remaining_nxt = '0;
              length_accum_nxt    = '0;
              prefix_count_nxt    = '0;
              phase_nxt           = PH_PREFIX;
            end else begin
              bytes_remaining_nxt = bytes_remaining_r - LEN_W'(1);
            end
          end
        end
        // halted, and the unused code: ignore everything
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // State and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_PREFIX;
      prefix_count_r    <= '0;
      length_accum_r    <= '0;
      bytes_remaining_r <= '0;
      max_size_r        <= MAX_SIZE_RESET;
    end else begin
      phase_r           <= phase_nxt;
      prefix_count_r    <= prefix_count_nxt;
      length_accum_r    <= length_accum_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
    end
  end

  assign status.halted     = (phase_r != PH_PREFIX) && (phase_r != PH_CONTENT);
  assign status.in_content = (phase_r == PH_CONTENT);

endmodule

`default_nettype wire

/* hw/rtl/vld_out_buf.sv */
// Result register with one skid entry so one more result is taken under stall.
// Depends on vld_pkg for the result word type.
`default_nettype none

module vld_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire vld_pkg::vld_out_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vld_pkg::vld_out_t      out_data
);
  import vld_pkg::*;

  logic     main_v_r;
  vld_out_t main_d_r;
  logic     skid_v_r;
  vld_out_t skid_d_r;

  // Main register drains first; skid catches a push while main is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || !out_stall) begin
      if (skid_v_r) begin
        main_d_r <= skid_d_r;
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
        if (push) begin
          main_d_r <= push_data;
        end
      end
    end else if (push) begin
      skid_d_r <= push_data;
      skid_v_r <= 1'b1;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

`default_nettype wire

/* tb/tb_varint_length_prefix_deframer.sv */
// Self-checking testbench for varint_length_prefix_deframer: byte streams of
// length-prefixed messages against an in-bench decoder. Depends on vld_pkg and the RTL.
module tb_varint_length_prefix_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import vld_pkg::*;

  typedef logic [LEN_W-1:0] len_t;
  typedef enum logic [1:0] {ST_PREFIX, ST_CONTENT, ST_HALTED} deframe_phase_t;

  localparam int unsigned SETTLE_CYCLES = 4;    // output latency plus result buffer
  localparam int unsigned IDLE_LIMIT    = 4000; // cycles with no handshake at all
  localparam int unsigned RANDOM_WORDS  = 1000;
  localparam len_t        LIMIT_TOP     = '1;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     cfg_wr_en   = 1'b0;
  len_t     cfg_wr_data = '0;
  logic     in_valid    = 1'b0;
  logic     in_stall;
  vld_in_t  in_data     = '0;
  logic     out_valid;
  logic     out_stall   = 1'b0;
  vld_out_t out_data;

  // Decoder state mirrored in the bench
  deframe_phase_t dec_phase = ST_PREFIX;
  logic [2:0]     dec_count = '0;
  len_t           dec_len   = '0;
  len_t           dec_left  = '0;
  len_t           max_size  = MAX_SIZE_RESET;
  vld_out_t       expected_words[$];

  int  sent_words     = 0;
  int  words_checked  = 0;
  int  messages_sent  = 0;
  int  limits_written = 0;
  int  mismatches     = 0;
  int  idle_cycles    = 0;
  int  burst_left     = 0;
  bit  bursty         = 1'b0;
  vld_err_t halt_kind = ERR_NONE;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  varint_length_prefix_deframer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  function automatic vld_in_t word_of(logic [7:0] b, logic err);
    vld_in_t w;
    w.data_byte  = b;
    w.link_error = err;
    return w;
  endfunction

  function automatic void push_error(vld_err_t kind);
    vld_out_t r;
    r = '0;
    r.error_kind = kind;
    expected_words.push_back(r);
    dec_phase = ST_HALTED;
  endfunction

  // Expected result, if any, of one accepted input word
  function automatic void predict_word(vld_in_t w);
    vld_out_t r;
    if (dec_phase != ST_PREFIX && dec_phase != ST_CONTENT) return;
    if (w.link_error) begin
      push_error(ERR_LINK);
      return;
    end
    if (dec_phase == ST_PREFIX) begin
      dec_count = dec_count + 3'd1;
      // three 7-bit groups, low first, then a full byte at bit 21
      case (dec_count)
        3'd1: dec_len |= len_t'(w.data_byte[6:0]);
        3'd2: dec_len |= len_t'(w.data_byte[6:0]) << 7;
        3'd3: dec_len |= len_t'(w.data_byte[6:0]) << 14;
        3'd4: dec_len |= len_t'(w.data_byte) << 21;
        default: ;
      endcase
      if (w.data_byte[7] && dec_count < PREFIX_BYTES) return;
      if (dec_len == '0) push_error(ERR_LEN_ZERO);
      else if (dec_len > max_size) push_error(ERR_LEN_MAX);
      else begin
        dec_left  = dec_len;
        dec_phase = ST_CONTENT;
      end
    end else begin
      r.payload_byte     = w.data_byte;
      r.first_of_message = (dec_left == dec_len);
      r.last_of_message  = (dec_left <= 1);
      r.error_kind       = ERR_NONE;
      expected_words.push_back(r);
      if (dec_left <= 1) begin
        dec_left  = '0;
        dec_len   = '0;
        dec_count = '0;
        dec_phase = ST_PREFIX;
      end else begin
        dec_left = dec_left - len_t'(1);
      end
    end
  endfunction

  function automatic void report_mismatch(string what, vld_out_t want, vld_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch, %s: expected byte %02h first %0b last %0b err %0d,",
               $time, what, want.payload_byte, want.first_of_message,
               want.last_of_message, want.error_kind,
               " got byte %02h first %0b last %0b err %0d",
               got.payload_byte, got.first_of_message, got.last_of_message,
               got.error_kind);
  endfunction

  // Result checker
  always @(posedge clk) begin
    vld_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("no result expected", '0, out_data);
      end else begin
        want = expected_words.pop_front();
        if (out_data.payload_byte !== want.payload_byte ||
            out_data.first_of_message !== want.first_of_message ||
            out_data.last_of_message !== want.last_of_message ||
            out_data.error_kind !== want.error_kind)
          report_mismatch("wrong field", want, out_data);
      end
    end
  end

  // Receiver stall pattern: free-flowing, light and heavy stretches
  int pat_mode = 0;
  int pat_left = 0;
  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_mode = $urandom_range(0, 2);
      pat_left = $urandom_range(10, 150);
    end else begin
      pat_left = pat_left - 1;
    end
    case (pat_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Send one word, with random gaps between bursts when bursty
  task automatic send_word(input vld_in_t w);
    int gap;
    if (bursty && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    sent_words++;
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_size(input len_t value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_size = value;
    limits_written++;
  endtask

  // Length prefix, minimal size plus pad extra continuation bytes
  task automatic send_prefix(input len_t len, input int unsigned pad);
    int unsigned nb;
    logic [7:0]  b;
    if (len < (1 << 7)) nb = 1;
    else if (len < (1 << 14)) nb = 2;
    else if (len < (1 << 21)) nb = 3;
    else nb = PREFIX_BYTES;
    nb = (nb + pad > PREFIX_BYTES) ? PREFIX_BYTES : nb + pad;
    for (int unsigned i = 0; i < nb; i++) begin
      if (i < 3) b = {((i + 1) < nb), len[7*i +: 7]};
      else b = len[LEN_W-1:21];
      send_word(word_of(b, 1'b0));
    end
  endtask

  // fill < 0 gives random content
  task automatic send_message(input len_t len, input int unsigned pad, input int fill);
    send_prefix(len, pad);
    for (int unsigned k = 0; k < len; k++)
      send_word(word_of((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0));
    messages_sent++;
  endtask

  function automatic len_t pick_len();
    int unsigned r;
    len_t        n;
    r = $urandom_range(0, 99);
    if (r < 80) n = len_t'($urandom_range(1, 16));
    else if (r < 95) n = len_t'($urandom_range(17, 140));
    else n = len_t'($urandom_range(141, 300));
    if (max_size <= 300 && $urandom_range(0, 7) == 0) n = max_size;
    if (n > max_size) n = len_t'($urandom_range(1, max_size));
    return n;
  endfunction

  function automatic int unsigned pick_pad();
    return ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
  endfunction

  // Reset limit: short messages, one-byte ones with both marks, padded prefixes
  task automatic test_directed();
    send_message(len_t'(1), 0, 'h00);
    send_message(len_t'(1), 3, 'hFF);
    send_message(len_t'(2), 1, -1);
    send_message(len_t'(3), 2, 'h5A);
  endtask

  // Smallest and largest limits, and a length right at the limit
  task automatic test_limit_extremes();
    len_t n;
    write_max_size(len_t'(1));
    repeat (3) send_message(len_t'(1), pick_pad(), -1);
    write_max_size(LIMIT_TOP);
    send_message(len_t'(5), 0, -1);
    n = len_t'($urandom_range(2, 40));
    write_max_size(n);
    send_message(n, pick_pad(), -1);
  endtask

  // Well-formed message streams over several limit settings
  task automatic test_random_traffic();
    len_t lim;
    int   target;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: lim = LIMIT_TOP;
        1: lim = len_t'($urandom_range(1, 8));
        2: lim = len_t'($urandom_range(9, 300));
        3: lim = MAX_SIZE_RESET;
        default: lim = len_t'($urandom_range(301, 20000));
      endcase
      write_max_size(lim);
      bursty = (ph != 0) && ($urandom_range(0, 3) != 0);
      target = sent_words + RANDOM_WORDS / 5;
      while (sent_words < target) send_message(pick_len(), pick_pad(), -1);
    end
    bursty = 1'b1;
  endtask

  // One error halts the block for the rest of the run; then noise is ignored
  task automatic test_halt_on_error();
    len_t len;
    len_t lim;
    halt_kind = vld_err_t'($urandom_range(ERR_LEN_ZERO, ERR_LINK));
    case (halt_kind)
      ERR_LINK: begin
        case ($urandom_range(0, 2))
          0: ;
          1: send_word(word_of(8'h80 | 8'($urandom_range(0, 127)), 1'b0));
          default: begin
            send_prefix(len_t'(6), 0);
            repeat (2) send_word(word_of(8'($urandom_range(0, 255)), 1'b0));
          end
        endcase
        send_word(word_of(8'($urandom_range(0, 255)), 1'b1));
      end
      ERR_LEN_ZERO: send_prefix('0, $urandom_range(0, 3));
      default: begin
        lim = ($urandom_range(0, 2) == 0) ? len_t'(0) : len_t'($urandom_range(1, 300));
        write_max_size(lim);
        if ($urandom_range(0, 1) == 0) begin
          len = len_t'(lim + $urandom_range(1, 300));
          send_prefix(len, pick_pad());
        end else begin
          len = {8'($urandom_range(1, 255)), 21'($urandom)};
          send_prefix(len, 0);
        end
      end
    endcase
    repeat (24)
      send_word(word_of(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_extremes();
    test_random_traffic();
    test_halt_on_error();
    drain_results();
    $display("covered %0d input words in %0d messages, %0d results checked, %0d limit writes",
             sent_words, messages_sent, words_checked, limits_written);
    $display("stream ended on error kind %s; %0d mismatches", halt_kind.name(), mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
